/* rtl/text_console_char_writer_unit_defines.svh */
// Assertion macros shared by the text console checker.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCCW_ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCCW_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/tccw_pkg.sv */
// Types and constants shared by the text console modules.
`default_nettype none
package tccw_pkg;

   typedef enum logic [1:0] {
      CMD_PUT        = 2'd0,
      CMD_CLEAR      = 2'd1,
      CMD_SET_CURSOR = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_FILL,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_from_rd;
   } mem_ctl_type;

   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 4;
   localparam int ATTR_W     = 8;
   localparam int CELL_W     = 16;
   localparam int COL_PORT_W = 7;
   localparam int ROW_PORT_W = 5;
   localparam int LOC_W      = 11;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LAST_PRINT = 8'h7F;

   localparam logic [ATTR_W-1:0]  RESET_ATTR      = 8'h0F;
   localparam logic [ATTR_W-1:0]  RESET_FILL_ATTR = 8'h0F;
   localparam logic [COLOR_W-1:0] CLEAR_FORE      = 4'hF;

endpackage
`default_nettype wire

/* rtl/tccw_buffer.sv */
// Text cell memory with a registered read port and a registered write stage.
`default_nettype none
module tccw_buffer import tccw_pkg::*; #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  mem_ctl_type       mem_ctl,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem [DEPTH];

   logic              wr_en_ff;
   logic              wr_from_rd_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic [CELL_W-1:0] wr_data_ff;
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= mem_ctl.wr_en;
      end
   end

   always_ff @(posedge clock) begin
      wr_from_rd_ff <= mem_ctl.wr_from_rd;
      wr_addr_ff    <= wr_addr;
      wr_data_ff    <= wr_data;
   end

   // A copy writes back the word that the read register captured for it.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         mem[wr_addr_ff] <= wr_from_rd_ff ? rd_data_ff : wr_data_ff;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/tccw_seq.sv */
// Command sequencer: cursor state, put-character logic and the buffer sweep counter.
`default_nettype none
module tccw_seq import tccw_pkg::*; #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8,
   parameter int CELLS     = 2000,
   parameter int ADDR_W    = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  cmd_type               req_command,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COLOR_W-1:0]    req_bg_color,
   input  logic [COLOR_W-1:0]    req_fg_color,
   input  logic [COL_PORT_W-1:0] req_column,
   input  logic [ROW_PORT_W-1:0] req_row,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [COL_PORT_W-1:0] rsp_cursor_col,
   output logic [ROW_PORT_W-1:0] rsp_cursor_row,
   output logic [LOC_W-1:0]      rsp_cursor_location,
   output logic [CELL_W-1:0]     rsp_cell_data,
   input  logic [ATTR_W-1:0]     fill_attr,
   output mem_ctl_type           mem_ctl,
   output logic [ADDR_W-1:0]     rd_addr,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [CELL_W-1:0]     wr_data,
   input  logic [CELL_W-1:0]     rd_data
);

   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int NCOL_W     = $clog2(COLUMNS + TAB_WIDTH);
   localparam int NROW_W     = ROW_W + 1;
   localparam int MOVE_CELLS = CELLS - COLUMNS;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic [COL_W-1:0]      cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]      cur_row_ff, cur_row_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COL_PORT_W-1:0] rsp_col_ff;
   logic [ROW_PORT_W-1:0] rsp_row_ff;
   logic [LOC_W-1:0]      rsp_loc_ff;
   logic [CELL_W-1:0]     rsp_cell_ff;

   cmd_type               cmd_ff;
   logic [CHAR_W-1:0]     char_ff;
   logic [COLOR_W-1:0]    back_ff;
   logic [COLOR_W-1:0]    fore_ff;
   logic [COL_PORT_W-1:0] col_arg_ff;
   logic [ROW_PORT_W-1:0] row_arg_ff;

   logic [NCOL_W-1:0] tab_stop [COLUMNS];
   logic [NCOL_W-1:0] col_ext;
   logic [NCOL_W-1:0] put_col;
   logic [NROW_W-1:0] put_row;
   logic [COL_W-1:0]  put_col_fin;
   logic [ROW_W-1:0]  put_row_fin;
   logic [COL_W-1:0]  put_wr_col;
   logic [ADDR_W-1:0] put_addr;
   logic [ADDR_W-1:0] arg_addr;
   logic              row_step;
   logic              col_wrap;
   logic              put_wr;
   logic              put_back;
   logic              printable;
   logic              scroll;
   logic              arg_col_ok;
   logic              arg_row_ok;
   logic              out_free;
   logic              accept;
   logic              load_rsp;
   logic              sweep_last;
   logic              move_last;

   for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
      assign tab_stop[g] = NCOL_W'(g + TAB_WIDTH - (g % TAB_WIDTH));
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sweep_last = (sweep_ff == ADDR_W'(CELLS - 1));
   assign move_last  = (sweep_ff == ADDR_W'(MOVE_CELLS - 1));
   assign arg_col_ok = int'(col_arg_ff) < COLUMNS;
   assign arg_row_ok = int'(row_arg_ff) < ROWS;
   assign arg_addr   = ADDR_W'(int'(row_arg_ff) * COLUMNS) + ADDR_W'(col_arg_ff);
   assign printable  = (char_ff >= CHAR_SPACE) && (char_ff <= CHAR_LAST_PRINT);
   assign col_ext    = NCOL_W'(cur_col_ff);

   always_comb begin
      put_col  = col_ext;
      row_step = 1'b0;
      put_wr   = 1'b0;
      put_back = 1'b0;
      priority if (char_ff == CHAR_BACKSPACE) begin
         if (cur_col_ff != '0) begin
            put_col  = col_ext - NCOL_W'(1);
            put_wr   = 1'b1;
            put_back = 1'b1;
         end
      end else if (char_ff == CHAR_TAB) begin
         put_col = tab_stop[cur_col_ff];
      end else if (char_ff == CHAR_CR) begin
         put_col = '0;
      end else if (char_ff == CHAR_LF) begin
         put_col  = '0;
         row_step = 1'b1;
      end else if (printable) begin
         put_col = col_ext + NCOL_W'(1);
         put_wr  = 1'b1;
      end else begin
         put_col = col_ext;
      end
   end

   assign col_wrap    = (put_col >= NCOL_W'(COLUMNS));
   assign put_col_fin = col_wrap ? '0 : COL_W'(put_col);
   assign put_row     = NROW_W'(cur_row_ff) + NROW_W'(row_step || col_wrap);
   assign scroll      = (put_row >= NROW_W'(ROWS));
   assign put_row_fin = scroll ? ROW_W'(ROWS - 1) : ROW_W'(put_row);
   assign put_wr_col  = cur_col_ff - COL_W'(put_back);
   assign put_addr    = ADDR_W'(int'(cur_row_ff) * COLUMNS) + ADDR_W'(put_wr_col);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_PUT: begin
                  if (scroll) begin
                     state_in = ST_SCROLL;
                  end else begin
                     state_in = out_free ? ST_IDLE : ST_DONE;
                  end
               end
               CMD_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               CMD_SET_CURSOR: begin
                  state_in = out_free ? ST_IDLE : ST_DONE;
               end
               CMD_READ: begin
                  state_in = (arg_col_ok && arg_row_ok) ? ST_READ : ST_DONE;
               end
            endcase
         end
         ST_SCROLL: begin
            if (move_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL, ST_CLEAR: begin
            if (sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      sweep_in   = sweep_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      cell_in    = cell_ff;
      load_rsp   = 1'b0;
      mem_ctl    = '0;
      rd_addr    = sweep_ff + ADDR_W'(COLUMNS);
      wr_addr    = sweep_ff;
      wr_data    = {fill_attr, CHAR_SPACE};
      unique case (state_ff)
         ST_INIT: begin
            mem_ctl.wr_en = 1'b1;
            wr_data       = {RESET_ATTR, CHAR_SPACE};
            sweep_in      = sweep_last ? '0 : sweep_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               cell_in = '0;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_PUT: begin
                  mem_ctl.wr_en = put_wr;
                  wr_addr       = put_addr;
                  wr_data       = {back_ff, fore_ff, put_back ? CHAR_SPACE : char_ff};
                  cur_col_in    = put_col_fin;
                  cur_row_in    = put_row_fin;
                  load_rsp      = !scroll && out_free;
               end
               CMD_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
               end
               CMD_SET_CURSOR: begin
                  cur_col_in = arg_col_ok ? COL_W'(col_arg_ff) : COL_W'(COLUMNS - 1);
                  cur_row_in = arg_row_ok ? ROW_W'(row_arg_ff) : ROW_W'(ROWS - 1);
                  load_rsp   = out_free;
               end
               CMD_READ: begin
                  mem_ctl.rd_en = arg_col_ok && arg_row_ok;
                  rd_addr       = arg_addr;
               end
            endcase
         end
         ST_SCROLL: begin
            mem_ctl.rd_en      = 1'b1;
            mem_ctl.wr_en      = 1'b1;
            mem_ctl.wr_from_rd = 1'b1;
            sweep_in           = sweep_ff + ADDR_W'(1);
         end
         ST_FILL: begin
            mem_ctl.wr_en = 1'b1;
            sweep_in      = sweep_last ? '0 : sweep_ff + ADDR_W'(1);
         end
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            wr_data       = {back_ff, CLEAR_FORE, CHAR_SPACE};
            sweep_in      = sweep_last ? '0 : sweep_ff + ADDR_W'(1);
         end
         ST_READ: begin
            cell_in = rd_data;
         end
         ST_DONE: begin
            load_rsp = out_free;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (accept) begin
         cmd_ff     <= req_command;
         char_ff    <= req_char_code;
         back_ff    <= req_bg_color;
         fore_ff    <= req_fg_color;
         col_arg_ff <= req_column;
         row_arg_ff <= req_row;
      end
      if (load_rsp) begin
         rsp_col_ff  <= COL_PORT_W'(cur_col_in);
         rsp_row_ff  <= ROW_PORT_W'(cur_row_in);
         rsp_loc_ff  <= LOC_W'(int'(cur_row_in) * COLUMNS + int'(cur_col_in));
         rsp_cell_ff <= cell_ff;
      end
   end

   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_cell_data       = rsp_cell_ff;

endmodule
`default_nettype wire

/* rtl/text_console_char_writer_unit.sv */
// Character-cell text console: COLUMNS x ROWS buffer of character and attribute words.
// Each command transfer returns one result transfer with the cursor after the command.
// After reset the buffer is swept to blanks (attribute 0x0F), one cell per cycle,
// and no command transfer is taken before the sweep ends. A new command is taken
// only once the last one has loaded its result; clear, or a put that scrolls, sweeps
// every cell through the single write port of the buffer memory, one cell per cycle.
`default_nettype none
module text_console_char_writer_unit import tccw_pkg::*; #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // command, char_code, bg_color, fg_color, column, row, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cursor_col, cursor_row, cursor_location, cell_data, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [ATTR_W-1:0]     csr_wr_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   logic [ATTR_W-1:0]     fill_attr_ff;
   mem_ctl_type           mem_ctl;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [CELL_W-1:0]     wr_data;
   logic [CELL_W-1:0]     rd_data;
   logic [COL_PORT_W-1:0] rsp_cursor_col;
   logic [ROW_PORT_W-1:0] rsp_cursor_row;
   logic [LOC_W-1:0]      rsp_cursor_location;
   logic [CELL_W-1:0]     rsp_cell_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_attr_ff <= RESET_FILL_ATTR;
      end else if (csr_wr_en) begin
         fill_attr_ff <= csr_wr_data;
      end
   end

   tccw_seq #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH),
      .CELLS     (CELLS),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_command         (cmd_type'(req_tdata[1:0])),
      .req_char_code       (req_tdata[9:2]),
      .req_bg_color        (req_tdata[13:10]),
      .req_fg_color        (req_tdata[17:14]),
      .req_column          (req_tdata[24:18]),
      .req_row             (req_tdata[29:25]),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_cell_data       (rsp_cell_data),
      .fill_attr           (fill_attr_ff),
      .mem_ctl             (mem_ctl),
      .rd_addr             (rd_addr),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data),
      .rd_data             (rd_data)
   );

   tccw_buffer #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_buffer (
      .clock   (clock),
      .reset   (reset),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign rsp_tdata = {1'b0, rsp_cell_data, rsp_cursor_location, rsp_cursor_row,
                       rsp_cursor_col};

endmodule
`default_nettype wire

/* rtl/tccw_checker.sv */
// Port-level assertions for the text console and the bind that attaches them.
`default_nettype none
`include "text_console_char_writer_unit_defines.svh"
module tccw_checker import tccw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   `TCCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `TCCW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "command taken while busy")
   `TCCW_ASSERT_IMPLIES(a_col_range, clock, reset, rsp_tvalid, int'(rsp_tdata[6:0]) < COLUMNS, "cursor column out of range")
   `TCCW_ASSERT_IMPLIES(a_row_range, clock, reset, rsp_tvalid, int'(rsp_tdata[11:7]) < ROWS, "cursor row out of range")
   `TCCW_ASSERT_IMPLIES(a_loc_match, clock, reset, rsp_tvalid, rsp_tdata[22:12] == 11'(int'(rsp_tdata[11:7]) * COLUMNS + int'(rsp_tdata[6:0])), "cursor location mismatch")

endmodule

bind text_console_char_writer_unit tccw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tccw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
